/* rtl/ie2ps2_pkg.sv */
// Package for the input event translator: payload structs, event and result
// codes, the job record passed from the front end to the back end, and the
// key remap and Pause tables. No dependencies.
package ie2ps2_pkg;

	localparam logic [15:0] EV_SYN = 16'd0;
	localparam logic [15:0] EV_KEY = 16'd1;
	localparam logic [15:0] EV_REL = 16'd2;
	localparam logic [15:0] EV_ABS = 16'd3;

	localparam logic [15:0] CODE_SYNC_FRAME = 16'h0000;
	localparam logic [15:0] CODE_X        = 16'h0000;
	localparam logic [15:0] CODE_Y        = 16'h0001;
	localparam logic [15:0] CODE_WHEEL    = 16'h0008;
	localparam logic [15:0] CODE_MT_SLOT  = 16'h002f;
	localparam logic [15:0] CODE_MT_FIRST = 16'h0030;
	localparam logic [15:0] CODE_MT_POS_X = 16'h0035;
	localparam logic [15:0] CODE_MT_POS_Y = 16'h0036;
	localparam logic [15:0] CODE_MT_TRACK = 16'h0039;
	localparam logic [15:0] CODE_MT_LAST  = 16'h003b;
	localparam logic [15:0] CODE_PAUSE    = 16'd119;
	localparam logic [15:0] CODE_BTN_LEFT = 16'h0110;
	localparam logic [15:0] CODE_BTN_RIGHT = 16'h0111;
	localparam logic [15:0] CODE_BTN_MID  = 16'h0112;
	localparam logic [15:0] CODE_KEY_LIMIT = 16'h0080;

	localparam logic [31:0] VAL_RELEASE  = 32'd0;
	localparam logic [31:0] VAL_REPEAT   = 32'd2;
	localparam logic [31:0] VAL_NO_TRACK = 32'hffffffff;

	localparam logic [1:0] KIND_SCAN = 2'd0;
	localparam logic [1:0] KIND_REL  = 2'd1;
	localparam logic [1:0] KIND_ABS  = 2'd2;

	localparam logic [7:0] SC_EXT_PREFIX = 8'he0;
	localparam logic [7:0] SC_BREAK_BIT  = 8'h80;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [15:0]        event_type;
		logic [15:0]        event_code;
		logic signed [31:0] event_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         scancode;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
		logic [2:0]         buttons;
		logic               last;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_KEY,
		JOB_PAUSE,
		JOB_SYNC
	} job_kind_t;

	// Slot mask: a key uses slot 0 for the prefix and slot 1 for the byte, Pause
	// uses all six slots, a sync report uses slot 0 relative, slot 1 the early
	// absolute report and slot 2 the main absolute report.
	typedef struct packed {
		job_kind_t          kind;
		logic [5:0]         slots;
		logic [7:0]         key_byte;
		logic signed [31:0] rel_x;
		logic signed [31:0] rel_y;
		logic signed [31:0] rel_z;
		logic [2:0]         rel_btn;
		logic signed [31:0] abs_x;
		logic signed [31:0] abs_y;
		logic signed [31:0] abs_z;
		logic [2:0]         pre_btn;
		logic [2:0]         abs_btn;
	} job_t;

	typedef struct packed {
		logic       found;
		logic       ext;
		logic [6:0] code;
	} remap_t;

	function automatic remap_t key_remap(input logic [15:0] code);
		remap_t r;
		r.found = 1'b1;
		r.ext   = 1'b1;
		r.code  = 7'h00;
		case (code)
			16'd94: begin r.ext = 1'b0; r.code = 7'h7b; end
			16'd92: begin r.ext = 1'b0; r.code = 7'h79; end
			16'd93: begin r.ext = 1'b0; r.code = 7'h70; end
			16'd124: begin r.ext = 1'b0; r.code = 7'h7d; end
			16'd89: begin r.ext = 1'b0; r.code = 7'h73; end
			16'd87: begin r.ext = 1'b0; r.code = 7'h57; end
			16'd88: begin r.ext = 1'b0; r.code = 7'h58; end
			16'd110: r.code = 7'h52;
			16'd102: r.code = 7'h47;
			16'd104: r.code = 7'h49;
			16'd111: r.code = 7'h53;
			16'd107: r.code = 7'h4f;
			16'd109: r.code = 7'h51;
			16'd103: r.code = 7'h48;
			16'd105: r.code = 7'h4b;
			16'd108: r.code = 7'h50;
			16'd106: r.code = 7'h4d;
			16'd100: r.code = 7'h38;
			16'd125: r.code = 7'h5b;
			16'd126: r.code = 7'h5c;
			16'd97: r.code = 7'h1d;
			16'd148: r.code = 7'h01;
			16'd99: r.code = 7'h37;
			16'd113: r.code = 7'h20;
			16'd114: r.code = 7'h2e;
			16'd115: r.code = 7'h30;
			16'd127: r.code = 7'h5d;
			16'd96: r.code = 7'h1c;
			16'd98: r.code = 7'h35;
			default: begin
				r.found = 1'b0;
				r.ext   = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pause_byte(input logic [5:0] sel);
		logic [7:0] b;
		case (sel)
			6'b000001: b = 8'he1;
			6'b000010: b = 8'h1d;
			6'b000100: b = 8'h45;
			6'b001000: b = 8'he1;
			6'b010000: b = 8'h9d;
			6'b100000: b = 8'hc5;
			default:   b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/ie2ps2_front.sv */
// Front end: classifies each accepted event, updates the touch, button and
// motion state, and builds a job record for the back end.
// Depends on ie2ps2_pkg.
module ie2ps2_front import ie2ps2_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t event_item,
	output logic     job_valid,
	output job_t     job
);

	logic               ts_q, tp_q, defer_q, am_q, relp_q, absp_q;
	logic [2:0]         mask_q, pb_q;
	logic signed [31:0] relx_q, rely_q, relz_q, absx_q, absy_q, absz_q;

	logic               ts_d, tp_d, defer_d, am_d, relp_d, absp_d;
	logic [2:0]         mask_d, pb_d;
	logic signed [31:0] relx_d, rely_d, relz_d, absx_d, absy_d, absz_d;

	logic        key_ev, abs_ev, rel_ev, sync_ev, now_pressed, rel_en, abs_en;
	logic [15:0] typ, cod, kcode, acode;
	logic [31:0] val, kval;
	logic [2:0]  pb_new, mask_main;
	logic [6:0]  kbase;
	remap_t      rm;

	always_comb begin
		typ = event_item.event_type;
		cod = event_item.event_code;
		val = event_item.event_value;

		ts_d = ts_q; tp_d = tp_q; defer_d = defer_q; am_d = am_q;
		relp_d = relp_q; absp_d = absp_q; mask_d = mask_q; pb_d = pb_q;
		relx_d = relx_q; rely_d = rely_q; relz_d = relz_q;
		absx_d = absx_q; absy_d = absy_q; absz_d = absz_q;

		job_valid = 1'b0;
		job = '0;
		job.kind = JOB_KEY;

		sync_ev = (typ == EV_SYN) && (cod == CODE_SYNC_FRAME);
		rel_ev = (typ == EV_REL);
		key_ev = (typ == EV_KEY);
		abs_ev = 1'b0;
		kcode = cod;
		kval = val;
		acode = cod;
		now_pressed = (val != VAL_NO_TRACK);
		pb_new = pb_q;
		mask_main = mask_q;
		rel_en = 1'b0;
		abs_en = 1'b0;
		rm = key_remap(kcode);
		kbase = 7'h00;

		if (sync_ev) begin
			ts_d = 1'b1;
		end

		if (typ == EV_ABS) begin
			if (cod == CODE_MT_POS_X) begin
				acode = CODE_X;
				abs_ev = ts_q;
			end else if (cod == CODE_MT_POS_Y) begin
				acode = CODE_Y;
				abs_ev = ts_q;
			end else if (cod == CODE_MT_TRACK) begin
				if (ts_q && (now_pressed != tp_q)) begin
					tp_d = now_pressed;
					key_ev = 1'b1;
					kcode = CODE_BTN_LEFT;
					kval = now_pressed ? VAL_REPEAT : VAL_RELEASE;
				end
			end else if (cod == CODE_MT_SLOT) begin
				ts_d = (val == 32'd0);
			end else if (!(cod inside {[CODE_MT_FIRST:CODE_MT_LAST]})) begin
				abs_ev = ts_q;
			end
		end

		rm = key_remap(kcode);

		if (key_ev) begin
			if (kcode >= CODE_BTN_LEFT) begin
				if (kcode == CODE_BTN_LEFT) begin
					pb_new = 3'b001;
				end else if (kcode == CODE_BTN_RIGHT) begin
					pb_new = 3'b010;
				end else if (kcode == CODE_BTN_MID) begin
					pb_new = 3'b100;
				end
				pb_d = pb_new;
				if (kval == VAL_REPEAT) begin
					defer_d = 1'b1;
				end else if (kval == VAL_RELEASE) begin
					mask_d = mask_q & ~pb_new;
				end else begin
					mask_d = mask_q | pb_new;
				end
			end else if (kcode == CODE_PAUSE) begin
				if (kval != VAL_RELEASE) begin
					job_valid = 1'b1;
					job.kind = JOB_PAUSE;
					job.slots = 6'b111111;
				end
			end else if (rm.found || (kcode < CODE_KEY_LIMIT)) begin
				kbase = rm.found ? rm.code : kcode[6:0];
				job_valid = 1'b1;
				job.kind = JOB_KEY;
				job.slots = {4'b0000, 1'b1, rm.ext};
				job.key_byte = (kval == VAL_RELEASE) ? ({1'b0, kbase} | SC_BREAK_BIT)
				                                     : {1'b0, kbase};
			end
		end

		if (rel_ev) begin
			am_d = 1'b0;
			relp_d = 1'b1;
			if (cod == CODE_X) begin
				relx_d = val;
			end else if (cod == CODE_Y) begin
				rely_d = val;
			end else if (cod == CODE_WHEEL) begin
				relz_d = 32'sd0 - val;
			end
		end

		if (abs_ev) begin
			am_d = 1'b1;
			absp_d = 1'b1;
			if (acode == CODE_X) begin
				absx_d = val;
			end else if (acode == CODE_Y) begin
				absy_d = val;
			end else if (acode == CODE_WHEEL) begin
				absz_d = 32'sd0 - val;
			end
		end

		if (sync_ev) begin
			rel_en = relp_q || (!absp_q && !am_q && (pb_q != 3'b000));
			abs_en = absp_q || (am_q && (pb_q != 3'b000));
			job.kind = JOB_SYNC;
			job.rel_x = relx_q;
			job.rel_y = rely_q;
			job.rel_z = relz_q;
			job.rel_btn = mask_q;
			job.abs_x = absx_q;
			job.abs_y = absy_q;
			job.abs_z = absz_q;
			job.pre_btn = mask_q;
			if (rel_en) begin
				relp_d = 1'b0;
				relx_d = '0;
				rely_d = '0;
				relz_d = '0;
			end
			if (abs_en) begin
				if (defer_q) begin
					mask_main = mask_q | pb_q;
					mask_d = mask_main;
				end
				absp_d = 1'b0;
				absz_d = '0;
			end
			job.abs_btn = mask_main;
			job.slots = {3'b000, abs_en, abs_en && defer_q && absp_q, rel_en};
			job_valid = rel_en || abs_en;
			pb_d = 3'b000;
			defer_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= 1'b1;
			tp_q <= 1'b0;
			defer_q <= 1'b0;
			am_q <= 1'b0;
			relp_q <= 1'b0;
			absp_q <= 1'b0;
			mask_q <= 3'b000;
			pb_q <= 3'b000;
			relx_q <= '0;
			rely_q <= '0;
			relz_q <= '0;
			absx_q <= '0;
			absy_q <= '0;
			absz_q <= '0;
		end else if (accept) begin
			ts_q <= ts_d;
			tp_q <= tp_d;
			defer_q <= defer_d;
			am_q <= am_d;
			relp_q <= relp_d;
			absp_q <= absp_d;
			mask_q <= mask_d;
			pb_q <= pb_d;
			relx_q <= relx_d;
			rely_q <= rely_d;
			relz_q <= relz_d;
			absx_q <= absx_d;
			absy_q <= absy_d;
			absz_q <= absz_d;
		end
	end

endmodule

/* rtl/ie2ps2_queue.sv */
// Short register queue of job records between the front and back ends.
// Depends on ie2ps2_pkg.
module ie2ps2_queue import ie2ps2_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic full,
	input  logic rd_en,
	output job_t rd_data,
	output logic empty
);

	job_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr, do_rd;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/ie2ps2_back.sv */
// Back end: expands a job record into result items, one per cycle while
// the registered output stage is free or popped. Depends on ie2ps2_pkg.
module ie2ps2_back import ie2ps2_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  job_t      q_data,
	output logic      q_rd,
	input  logic      pop,
	output logic      empty,
	output out_item_t result_item
);

	job_t       cur_q;
	logic [5:0] slots_q, sel;
	logic       out_valid_q, slot_free, advance, is_last, load;
	out_item_t  out_q, res;

	always_comb begin
		sel = slots_q & (~slots_q + 6'd1);
		is_last = ((slots_q & ~sel) == 6'b000000);
		slot_free = !out_valid_q || pop;
		advance = slot_free && (slots_q != 6'b000000);
		load = ((slots_q == 6'b000000) || (advance && is_last)) && !q_empty;
		q_rd = load;

		res = '0;
		res.last = is_last;
		case (cur_q.kind)
			JOB_KEY: begin
				res.kind = KIND_SCAN;
				res.scancode = sel[0] ? SC_EXT_PREFIX : cur_q.key_byte;
			end
			JOB_PAUSE: begin
				res.kind = KIND_SCAN;
				res.scancode = pause_byte(sel);
			end
			JOB_SYNC: begin
				if (sel[0]) begin
					res.kind = KIND_REL;
					res.move_x = cur_q.rel_x;
					res.move_y = cur_q.rel_y;
					res.move_z = cur_q.rel_z;
					res.buttons = cur_q.rel_btn;
				end else begin
					res.kind = KIND_ABS;
					res.move_x = cur_q.abs_x;
					res.move_y = cur_q.abs_y;
					res.move_z = cur_q.abs_z;
					res.buttons = sel[1] ? cur_q.pre_btn : cur_q.abs_btn;
				end
			end
			default: begin
				res.kind = KIND_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 6'b000000;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				slots_q <= q_data.slots;
			end else if (advance) begin
				slots_q <= slots_q & ~sel;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign result_item = out_q;

endmodule

/* rtl/input_event_to_ps2_and_mouse.sv */
// Input event translator: events to PS/2 set-1 scancodes and mouse reports.
// An event is taken every cycle while the job queue has room; its job is written
// into the queue, loaded into the back end, then registered in the output stage.
// Results leave one per cycle while pop is held; Pause gives the most, six.
// Reset clears all touch, button and motion state and empties the queue.
// Depends on ie2ps2_pkg, ie2ps2_front, ie2ps2_queue and ie2ps2_back.
module input_event_to_ps2_and_mouse import ie2ps2_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  event_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result_item
);

	logic accept, job_valid, q_empty, q_rd;
	job_t job, q_data;

	assign accept = push && !full;

	ie2ps2_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.event_item (event_item),
		.job_valid  (job_valid),
		.job        (job)
	);

	ie2ps2_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && job_valid),
		.wr_data (job),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	ie2ps2_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.result_item (result_item)
	);

endmodule

/* verif/tb_input_event_to_ps2_and_mouse.sv */
// Testbench for input_event_to_ps2_and_mouse: drives key, motion, touch and sync events
// and checks every scancode byte and mouse report against a predictor of its own.
// Depends on ie2ps2_pkg and the top level of the translator.
module tb_input_event_to_ps2_and_mouse;
	timeunit 1ns;
	timeprecision 1ps;
	import ie2ps2_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int MAX_GAP       = 11;
	localparam int HOLD_CYCLES   = 60;
	localparam int RANDOM_EVENTS = 200;
	localparam int DRAIN_CYCLES  = 20;
	localparam int IDLE_LIMIT    = 2000;

	class evdev_scoreboard;
		out_item_t   expected_out[$];
		int          errors;
		int          step_count;
		bit          slot_zero, touch_down, defer_btn, abs_mode, rel_dirty, abs_dirty;
		logic [2:0]  btn_mask, btn_sel;
		logic [31:0] rel_x, rel_y, rel_z, abs_x, abs_y, abs_z;
		logic [7:0]  pause_seq [6];

		function new();
			pause_seq = '{8'he1, 8'h1d, 8'h45, 8'he1, 8'h9d, 8'hc5};
			errors = 0;
			slot_zero = 1'b1;
			touch_down = 1'b0;
			defer_btn = 1'b0;
			abs_mode = 1'b0;
			rel_dirty = 1'b0;
			abs_dirty = 1'b0;
			btn_mask = '0;
			btn_sel = '0;
			rel_x = '0;
			rel_y = '0;
			rel_z = '0;
			abs_x = '0;
			abs_y = '0;
			abs_z = '0;
		endfunction

		function void queue_result(logic [1:0] kind, logic [7:0] sc, logic [31:0] x,
				logic [31:0] y, logic [31:0] z, logic [2:0] b);
			out_item_t r;
			r.kind = kind;
			r.scancode = sc;
			r.move_x = x;
			r.move_y = y;
			r.move_z = z;
			r.buttons = b;
			r.last = 1'b0;
			expected_out.push_back(r);
			step_count++;
		endfunction

		function bit remap_key(input logic [15:0] code, output bit ext, output logic [6:0] sc);
			ext = 1'b1;
			remap_key = 1'b1;
			case (code)
				16'd94:  begin ext = 1'b0; sc = 7'h7b; end
				16'd92:  begin ext = 1'b0; sc = 7'h79; end
				16'd93:  begin ext = 1'b0; sc = 7'h70; end
				16'd124: begin ext = 1'b0; sc = 7'h7d; end
				16'd89:  begin ext = 1'b0; sc = 7'h73; end
				16'd87:  begin ext = 1'b0; sc = 7'h57; end
				16'd88:  begin ext = 1'b0; sc = 7'h58; end
				16'd96:  sc = 7'h1c;
				16'd97:  sc = 7'h1d;
				16'd98:  sc = 7'h35;
				16'd99:  sc = 7'h37;
				16'd100: sc = 7'h38;
				16'd102: sc = 7'h47;
				16'd103: sc = 7'h48;
				16'd104: sc = 7'h49;
				16'd105: sc = 7'h4b;
				16'd106: sc = 7'h4d;
				16'd107: sc = 7'h4f;
				16'd108: sc = 7'h50;
				16'd109: sc = 7'h51;
				16'd110: sc = 7'h52;
				16'd111: sc = 7'h53;
				16'd113: sc = 7'h20;
				16'd114: sc = 7'h2e;
				16'd115: sc = 7'h30;
				16'd125: sc = 7'h5b;
				16'd126: sc = 7'h5c;
				16'd127: sc = 7'h5d;
				16'd148: sc = 7'h01;
				default: begin
					ext = 1'b0;
					sc = 7'h00;
					remap_key = 1'b0;
				end
			endcase
		endfunction

		function void key_event(logic [15:0] code, logic [31:0] val);
			bit         ext;
			logic [6:0] mapped;
			logic [15:0] key;
			if (code == CODE_PAUSE) begin
				if (val != VAL_RELEASE)
					foreach (pause_seq[i])
						queue_result(KIND_SCAN, pause_seq[i], '0, '0, '0, '0);
				return;
			end
			key = code;
			if (remap_key(code, ext, mapped)) begin
				if (ext)
					queue_result(KIND_SCAN, SC_EXT_PREFIX, '0, '0, '0, '0);
				key = {9'd0, mapped};
			end
			if (key < CODE_KEY_LIMIT)
				queue_result(KIND_SCAN, (val == VAL_RELEASE) ? (key[7:0] | SC_BREAK_BIT) :
					(key[7:0] & ~SC_BREAK_BIT), '0, '0, '0, '0);
		endfunction

		function void sync_report();
			if (rel_dirty || (!abs_dirty && !abs_mode && btn_sel != 3'd0)) begin
				queue_result(KIND_REL, '0, rel_x, rel_y, rel_z, btn_mask);
				rel_dirty = 1'b0;
				rel_x = '0;
				rel_y = '0;
				rel_z = '0;
			end
			if (abs_dirty || (!rel_dirty && abs_mode && btn_sel != 3'd0)) begin
				if (defer_btn) begin
					if (abs_dirty) begin
						queue_result(KIND_ABS, '0, abs_x, abs_y, abs_z, btn_mask);
						abs_dirty = 1'b0;
					end
					btn_mask = btn_mask | btn_sel;
				end
				queue_result(KIND_ABS, '0, abs_x, abs_y, abs_z, btn_mask);
				abs_dirty = 1'b0;
				abs_z = '0;
			end
			btn_sel = '0;
			defer_btn = 1'b0;
		endfunction

		function void apply_event(in_item_t it);
			logic [15:0] ty, code;
			logic [31:0] val;
			bit          now;
			ty = it.event_type;
			code = it.event_code;
			val = it.event_value;
			if (ty == EV_SYN && code == CODE_SYNC_FRAME)
				slot_zero = 1'b1;
			if (ty == EV_ABS) begin
				if (code == CODE_MT_POS_X) begin
					code = CODE_X;
				end else if (code == CODE_MT_POS_Y) begin
					code = CODE_Y;
				end else if (code == CODE_MT_TRACK) begin
					if (!slot_zero)
						return;
					now = (val != VAL_NO_TRACK);
					if (now == touch_down)
						return;
					touch_down = now;
					ty = EV_KEY;
					code = CODE_BTN_LEFT;
					val = now ? VAL_REPEAT : VAL_RELEASE;
				end else if (code == CODE_MT_SLOT) begin
					slot_zero = (val == 32'd0);
					return;
				end else if (code >= CODE_MT_FIRST && code <= CODE_MT_LAST) begin
					return;
				end
				if (ty == EV_ABS && !slot_zero)
					return;
			end
			if (ty == EV_KEY) begin
				if (code >= CODE_BTN_LEFT) begin
					if (code == CODE_BTN_LEFT)
						btn_sel = 3'b001;
					else if (code == CODE_BTN_RIGHT)
						btn_sel = 3'b010;
					else if (code == CODE_BTN_MID)
						btn_sel = 3'b100;
					if (val == VAL_REPEAT)
						defer_btn = 1'b1;
					else if (val == VAL_RELEASE)
						btn_mask = btn_mask & ~btn_sel;
					else
						btn_mask = btn_mask | btn_sel;
				end else begin
					key_event(code, val);
				end
			end else if (ty == EV_REL) begin
				abs_mode = 1'b0;
				if (code == CODE_X)
					rel_x = val;
				else if (code == CODE_Y)
					rel_y = val;
				else if (code == CODE_WHEEL)
					rel_z = -val;
				rel_dirty = 1'b1;
			end else if (ty == EV_ABS) begin
				abs_mode = 1'b1;
				if (code == CODE_X)
					abs_x = val;
				else if (code == CODE_Y)
					abs_y = val;
				else if (code == CODE_WHEEL)
					abs_z = -val;
				abs_dirty = 1'b1;
			end else if (ty == EV_SYN && code == CODE_SYNC_FRAME) begin
				sync_report();
			end
		endfunction

		function void note_event(in_item_t it);
			out_item_t tail;
			step_count = 0;
			apply_event(it);
			if (step_count > 0) begin
				tail = expected_out.pop_back();
				tail.last = 1'b1;
				expected_out.push_back(tail);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d scancode %h",
					$time, got.kind, got.scancode);
				errors++;
				return;
			end
			want = expected_out.pop_front();
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("scancode", 32'(want.scancode), 32'(got.scancode));
			compare_field("move_x", want.move_x, got.move_x);
			compare_field("move_y", want.move_y, got.move_y);
			compare_field("move_z", want.move_z, got.move_z);
			compare_field("buttons", 32'(want.buttons), 32'(got.buttons));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  event_item;
	logic      empty;
	logic      pop;
	out_item_t result_item;

	evdev_scoreboard sb;
	int accepted_events;
	int idle_cycles;
	bit send_quiet;
	bit recv_quiet;
	bit hold_request;
	bit second_hold;

	input_event_to_ps2_and_mouse DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.event_item(event_item),
		.empty(empty),
		.pop(pop),
		.result_item(result_item)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (push && !full)
				sb.note_event(event_item);
			if (pop && !empty)
				sb.check_result(result_item);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_event(input logic [15:0] ty, input logic [15:0] code,
			input logic [31:0] val);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if ($urandom_range(0, 15) == 0)
			send_quiet = !send_quiet;
		repeat (gap) @(negedge clk) push <= 1'b0;
		@(negedge clk);
		push <= 1'b1;
		event_item <= {ty, code, val};
		do @(posedge clk); while (full);
		if (ty <= EV_ABS)
			accepted_events++;
	endtask

	task automatic drain_results();
		int gap;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
				if ($urandom_range(0, 15) == 0)
					recv_quiet = !recv_quiet;
			end
			repeat (gap) @(negedge clk) pop <= 1'b0;
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: pick_value = 32'd0;
			1: pick_value = 32'd1;
			2: pick_value = 32'd2;
			3: pick_value = 32'hffffffff;
			4: pick_value = 32'h7fffffff;
			5: pick_value = 32'h80000000;
			default: pick_value = $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_key_code();
		case ($urandom_range(0, 5))
			0: pick_key_code = 16'($urandom_range(0, 127));
			1: pick_key_code = 16'($urandom_range(87, 148));
			2: pick_key_code = CODE_PAUSE;
			3: pick_key_code = 16'($urandom_range(128, 16'h010f));
			4: pick_key_code = 16'($urandom_range(CODE_BTN_LEFT, CODE_BTN_MID + 1));
			default: pick_key_code = 16'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	function automatic logic [31:0] pick_key_value();
		case ($urandom_range(0, 4))
			0: pick_key_value = VAL_RELEASE;
			1: pick_key_value = 32'd1;
			2: pick_key_value = VAL_REPEAT;
			default: pick_key_value = pick_value();
		endcase
	endfunction

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 4))
			0: pick_axis = CODE_X;
			1: pick_axis = CODE_Y;
			2: pick_axis = CODE_WHEEL;
			default: pick_axis = 16'($urandom_range(0, 15));
		endcase
	endfunction

	task automatic send_motion(input logic [15:0] ty);
		int n;
		n = $urandom_range(1, 3);
		repeat (n) send_event(ty, pick_axis(), pick_value());
		if ($urandom_range(0, 1))
			send_event(EV_KEY, 16'($urandom_range(CODE_BTN_LEFT, CODE_BTN_MID)),
				pick_key_value());
		send_event(EV_SYN, CODE_SYNC_FRAME, pick_value());
	endtask

	task automatic send_touch();
		if ($urandom_range(0, 2) == 0)
			send_event(EV_ABS, CODE_MT_SLOT, ($urandom_range(0, 4) == 0) ? pick_value() : 32'd0);
		send_event(EV_ABS, CODE_MT_TRACK, $urandom_range(0, 1) ? VAL_NO_TRACK : pick_value());
		if ($urandom_range(0, 1))
			send_event(EV_ABS, CODE_MT_POS_X, pick_value());
		if ($urandom_range(0, 1))
			send_event(EV_ABS, CODE_MT_POS_Y, pick_value());
		if ($urandom_range(0, 3) == 0)
			send_event(EV_ABS, 16'($urandom_range(CODE_MT_SLOT, CODE_MT_LAST + 1)),
				pick_value());
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
	endtask

	task automatic send_packet();
		case ($urandom_range(0, 9))
			0, 1, 2: repeat ($urandom_range(1, 3)) send_event(EV_KEY, pick_key_code(),
				pick_key_value());
			3, 4: send_motion(EV_REL);
			5: send_motion(EV_ABS);
			6, 7: send_touch();
			8: send_event(16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 16'hffff)),
				$urandom);
			default: send_event(16'($urandom_range(EV_SYN, EV_ABS + 1)),
				16'($urandom_range(0, 16'h003f)), pick_value());
		endcase
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		event_item = '0;
		idle_cycles = 0;
		accepted_events = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			drain_results();
		join_none

		send_event(EV_KEY, 16'h001e, 32'd1);
		send_event(EV_KEY, 16'h0000, VAL_REPEAT);
		send_event(EV_KEY, 16'h007f, VAL_RELEASE);
		send_event(EV_KEY, 16'd94, 32'd1);
		send_event(EV_KEY, 16'd110, VAL_RELEASE);
		send_event(EV_KEY, CODE_PAUSE, 32'd1);
		send_event(EV_KEY, CODE_PAUSE, VAL_RELEASE);
		send_event(EV_KEY, CODE_KEY_LIMIT, 32'd1);
		send_event(EV_REL, CODE_X, 32'h7fffffff);
		send_event(EV_REL, CODE_Y, 32'h80000000);
		send_event(EV_REL, CODE_WHEEL, 32'h80000000);
		send_event(EV_KEY, CODE_BTN_MID, 32'd1);
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
		send_event(EV_KEY, 16'hffff, VAL_RELEASE);
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
		send_event(EV_ABS, CODE_X, 32'hffffffff);
		send_event(EV_KEY, CODE_BTN_RIGHT, VAL_REPEAT);
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
		send_event(EV_ABS, CODE_MT_SLOT, 32'd3);
		send_event(EV_ABS, CODE_MT_TRACK, 32'd5);
		send_event(EV_ABS, CODE_Y, 32'd7);
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
		send_event(EV_ABS, CODE_MT_TRACK, 32'd9);
		send_event(EV_ABS, CODE_MT_POS_X, 32'd100);
		send_event(EV_ABS, CODE_MT_LAST, 32'd1);
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
		send_event(EV_ABS, CODE_MT_TRACK, VAL_NO_TRACK);
		send_event(EV_SYN, CODE_SYNC_FRAME, 32'd0);
		send_event(16'hffff, 16'hffff, 32'hffffffff);
		send_event(EV_SYN, 16'h0001, 32'd0);

		accepted_events = 0;
		hold_request = 1'b1;
		while (accepted_events < RANDOM_EVENTS) begin
			if (!second_hold && accepted_events >= RANDOM_EVENTS / 2) begin
				hold_request = 1'b1;
				second_hold = 1'b1;
			end
			send_packet();
		end
		@(negedge clk);
		push <= 1'b0;

		while (sb.expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* input_event_to_ps2_and_mouse.f */
rtl/ie2ps2_pkg.sv
rtl/ie2ps2_front.sv
rtl/ie2ps2_queue.sv
rtl/ie2ps2_back.sv
rtl/input_event_to_ps2_and_mouse.sv
verif/tb_input_event_to_ps2_and_mouse.sv
